// ----- rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int BYTE_W          = 8;
   localparam int WINDOW_DEPTH    = 16;
   localparam int LEN_W           = 5;
   localparam int IDX_W           = 4;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int PATTERN_MAX     = 16;
   localparam int REPLACEMENT_MAX = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_HIGH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LEN  = 3'd5;

   typedef logic [WINDOW_DEPTH-1:0][BYTE_W-1:0] byte_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              stream_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic              run_last;
      logic              text_done;
   } rsp_type;

   // one queued burst of result bytes
   typedef struct packed {
      byte_row_type     bytes;
      logic             use_repl;
      logic [IDX_W-1:0] last_idx;
      logic             stream_end;
   } job_type;

endpackage

// ----- rtl/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Accepts text beats, keeps the match window and classifies each beat into
// a burst job: window bytes, replacement bytes, or nothing.
// ----------------------------------------------------------------------------
module sfr_front
   import sfr_pkg::*;
#(
   parameter int PAT_MAX = PATTERN_MAX,
   parameter int REP_MAX = REPLACEMENT_MAX
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   input  byte_row_type     pattern_bytes,
   input  logic [LEN_W-1:0] pattern_length,
   input  logic [LEN_W-1:0] replacement_length,
   input  logic             queue_full,
   output logic             push,
   output job_type          push_job
);

   localparam int PAT_CAP_I = (PAT_MAX < WINDOW_DEPTH) ? PAT_MAX : WINDOW_DEPTH;
   localparam int REP_CAP_I = (REP_MAX < WINDOW_DEPTH) ? REP_MAX : WINDOW_DEPTH;
   localparam logic [LEN_W-1:0] PAT_CAP = LEN_W'(PAT_CAP_I);
   localparam logic [LEN_W-1:0] REP_CAP = LEN_W'(REP_CAP_I);

   byte_row_type     window_ff, window_in;
   logic [LEN_W-1:0] fill_ff, fill_in;

   byte_row_type     w_app;
   logic [LEN_W-1:0] fill_app;
   logic [LEN_W-1:0] plen, rlen, count;
   logic             hit, use_repl, accept;

   assign plen     = (pattern_length > PAT_CAP) ? PAT_CAP : pattern_length;
   assign rlen     = (replacement_length > REP_CAP) ? REP_CAP : replacement_length;
   assign req_stall = queue_full;
   assign accept   = req_valid && !req_stall;
   assign fill_app = fill_ff + LEN_W'(1);

   always_comb begin
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         w_app[i] = (LEN_W'(i) == fill_ff) ? req_data.text_byte : window_ff[i];
         if ((LEN_W'(i) < plen) && (w_app[i] != pattern_bytes[i])) begin
            ok = 1'b0;
         end
      end
      hit = ok;
   end

   always_comb begin
      window_in = w_app;
      use_repl  = 1'b0;
      count     = fill_app;
      fill_in   = '0;
      if (fill_app > plen) begin
         count = fill_app;
      end else if (fill_app == plen) begin
         if (hit) begin
            use_repl = 1'b1;
            count    = rlen;
         end else if (!req_data.stream_end) begin
            count   = LEN_W'(1);
            fill_in = fill_app - LEN_W'(1);
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
               window_in[i] = w_app[i+1];
            end
         end
      end else if (!req_data.stream_end) begin
         count   = '0;
         fill_in = fill_app;
      end
   end

   assign push                = accept && (count != '0);
   assign push_job.bytes      = w_app;
   assign push_job.use_repl   = use_repl;
   assign push_job.last_idx   = IDX_W'(count - LEN_W'(1));
   assign push_job.stream_end = req_data.stream_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

// ----- rtl/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
module sfr_queue
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Walks the head job one byte per cycle, while rsp_stall does not hold the output, into the result output register.
// ----------------------------------------------------------------------------
module sfr_back
   import sfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  job_type      head_job,
   input  byte_row_type replacement_bytes,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             load, last;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign last = (idx_ff == head_job.last_idx);
   assign pop  = load && last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = head_valid;
      end
      if (load) begin
         idx_in                  = last ? '0 : idx_ff + IDX_W'(1);
         rsp_data_in.result_byte = head_job.use_repl ? replacement_bytes[idx_ff]
                                                     : head_job.bytes[idx_ff];
         rsp_data_in.run_last    = last;
         rsp_data_in.text_done   = last && head_job.stream_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/stream_find_and_replace.sv -----
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming byte find-and-replace with a configurable pattern and replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one text byte per beat plus a stream_end flag on the last
//   byte of a text. rsp_ returns the substituted text, one byte per beat;
//   run_last marks the last result of an input beat and text_done the last
//   result of the whole text. A beat that completes a match with an empty
//   replacement, or that only fills the window, produces no result.
//   csr_ writes the six registers (pattern low/high, pattern length,
//   replacement low/high, replacement length); csr_ready is always high.
//   Write them only while no results are outstanding.
//   Each result is registered in the job queue and then in the result
//   output register. Throughput: one input beat per cycle while each beat
//   causes at most one result and rsp_stall is low; a beat causing k
//   results holds the emitter until all k are out, and req_stall rises
//   once the two-entry job queue fills.
//   Reset clears the fill count, queue pointers and count, output valid
//   flag and CSR registers, not the window or result bytes. While rsp_stall
//   is high the result beat holds; the queue takes input until full.
// ----------------------------------------------------------------------------
module stream_find_and_replace
   import sfr_pkg::*;
#(
   parameter int PAT_MAX = PATTERN_MAX,
   parameter int REP_MAX = REPLACEMENT_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_hi_ff, rep_lo_ff, rep_hi_ff;
   logic [LEN_W-1:0]      pat_len_ff, rep_len_ff;
   byte_row_type          pattern_bytes, replacement_bytes;
   logic                  csr_write;

   logic    push, pop, queue_full, head_valid;
   job_type push_job, head_job;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= '0;
         rep_lo_ff  <= '0;
         rep_hi_ff  <= '0;
         rep_len_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_LOW:      pat_lo_ff  <= csr_data;
            CSR_PATTERN_HIGH:     pat_hi_ff  <= csr_data;
            CSR_PATTERN_LENGTH:   pat_len_ff <= csr_data[LEN_W-1:0];
            CSR_REPLACEMENT_LOW:  rep_lo_ff  <= csr_data;
            CSR_REPLACEMENT_HIGH: rep_hi_ff  <= csr_data;
            CSR_REPLACEMENT_LEN:  rep_len_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_bytes     = {pat_hi_ff, pat_lo_ff};
   assign replacement_bytes = {rep_hi_ff, rep_lo_ff};

   sfr_front #(
      .PAT_MAX (PAT_MAX),
      .REP_MAX (REP_MAX)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .pattern_bytes      (pattern_bytes),
      .pattern_length     (pat_len_ff),
      .replacement_length (rep_len_ff),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   sfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .replacement_bytes (replacement_bytes),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data)
   );

endmodule
